// File: rtl/core/dtlv_pkg.sv
// Shared types and constants for the DER tag-length header parser.
// Used by dtlv_front, dtlv_queue, dtlv_back and der_tlv_header_parser_core.
package dtlv_pkg;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_BUF_SHORT  = 3'd1,
    ST_BAD_FORM   = 3'd2,
    ST_LEN_PAST   = 3'd3,
    ST_LEAD_ZERO  = 3'd4,
    ST_SHORT_REQ  = 3'd5,
    ST_BODY_PAST  = 3'd6
  } status_t;

  typedef struct packed {
    logic [7:0]  tag_byte;
    logic [31:0] content_length;
    logic [2:0]  head_len;
    status_t     status;
  } result_t;

  localparam logic [7:0] TAG_CONS_MASK  = 8'h20;
  localparam logic [7:0] LEN_LONG_MASK  = 8'h80;
  localparam logic [6:0] LEN_COUNT_MASK = 7'h7F;
  localparam logic [31:0] SHORT_LIMIT   = 32'd128;
  localparam logic [2:0] TAG_LEN_HDR    = 3'd2;
  localparam int unsigned QDEPTH        = 2;
  localparam int unsigned QPTR_W        = 1;
  localparam int unsigned QCNT_W        = 2;

endpackage

// File: rtl/core/der_tlv_header_parser_core.sv
// DER tag-length header parser, top level. Uses dtlv_front, dtlv_queue, dtlv_back, dtlv_pkg.
// Throughput: one buffer word per cycle while the two-entry result queue has room.
// Each result is written into the queue on the edge that accepts the word settling it,
// then loaded into the output register once the output stage is empty or being popped.
// Reset: synchronous on rst_n low; phase idle, queue and output stage empty.
module der_tlv_header_parser_core #(
  parameter int unsigned MAX_LEN_OCTETS = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_push,
  output logic        in_full,
  input  logic [7:0]  in_data_byte,
  input  logic        in_start_req,
  input  logic [31:0] in_available_bytes,
  output logic        out_empty,
  input  logic        out_pop,
  output logic [7:0]  out_tag_byte,
  output logic        out_constructed,
  output logic [31:0] out_content_length,
  output logic [2:0]  out_head_len,
  output logic [2:0]  out_status
);

  logic                               accept;
  logic                               res_push;
  dtlv_pkg::result_t                  res_data;
  logic                               q_pop;
  logic                               q_valid;
  dtlv_pkg::result_t                  q_head;
  logic [dtlv_pkg::QCNT_W-1:0]        q_count;

  assign accept = in_push & ~in_full;

  dtlv_front #(
    .MAX_LEN_OCTETS(MAX_LEN_OCTETS)
  ) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .accept         (accept),
    .data_byte      (in_data_byte),
    .start_req      (in_start_req),
    .available_bytes(in_available_bytes),
    .res_push       (res_push),
    .res_data       (res_data)
  );

  dtlv_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (res_push),
    .push_data(res_data),
    .pop      (q_pop),
    .full     (in_full),
    .valid    (q_valid),
    .head     (q_head),
    .count    (q_count)
  );

  dtlv_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .q_valid           (q_valid),
    .q_head            (q_head),
    .q_pop             (q_pop),
    .out_pop           (out_pop),
    .out_empty         (out_empty),
    .out_tag_byte      (out_tag_byte),
    .out_constructed   (out_constructed),
    .out_content_length(out_content_length),
    .out_head_len      (out_head_len),
    .out_status        (out_status)
  );

`ifndef SYNTHESIS
  a_short_buf_queued: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_start_req && in_available_bytes < 32'd2) |=> (q_count != '0))
    else $error("short buffer word did not queue a result");

  a_error_zeroed: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_status != dtlv_pkg::ST_OK) |->
      (out_tag_byte == 8'd0 && !out_constructed && out_content_length == 32'd0 &&
       out_head_len == 3'd0))
    else $error("error result carries header fields");

  a_ok_hdr_len: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_status == dtlv_pkg::ST_OK) |->
      (out_head_len >= 3'd2 && 32'(out_head_len) <= 32'(MAX_LEN_OCTETS + 2)))
    else $error("header length out of range");
`endif

endmodule

// File: rtl/core/dtlv_front.sv
// Front end: accepts buffer words, tracks the header phase and builds result records.
// Depends on dtlv_pkg.
module dtlv_front #(
  parameter int unsigned MAX_LEN_OCTETS = 4
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              accept,
  input  logic [7:0]        data_byte,
  input  logic              start_req,
  input  logic [31:0]       available_bytes,
  output logic              res_push,
  output dtlv_pkg::result_t res_data
);

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_LEN  = 2'd1,
    PH_LONG = 2'd2,
    PH_SKIP = 2'd3
  } phase_t;

  phase_t      phase_r, phase_nxt;
  logic [7:0]  tag_r, tag_nxt;
  logic [31:0] size_r, size_nxt;
  logic [31:0] acc_r, acc_nxt;
  logic [2:0]  tot_r, tot_nxt;
  logic [2:0]  left_r, left_nxt;

  logic [31:0] acc_shift;
  logic [6:0]  n_oct;
  logic [31:0] fin_len;
  logic [2:0]  fin_hdr;
  logic [32:0] fin_sum;
  logic        fin_past;
  logic        emit;
  dtlv_pkg::status_t st;

  always_comb begin
    acc_shift = {acc_r[23:0], data_byte};
    n_oct     = data_byte[6:0] & dtlv_pkg::LEN_COUNT_MASK;
    fin_len   = (phase_r == PH_LEN) ? {24'd0, data_byte} : acc_shift;
    fin_hdr   = (phase_r == PH_LEN) ? dtlv_pkg::TAG_LEN_HDR : dtlv_pkg::TAG_LEN_HDR + tot_r;
    fin_sum   = {1'b0, fin_len} + {30'd0, fin_hdr};
    fin_past  = fin_sum > {1'b0, size_r};
  end

  always_comb begin
    phase_nxt = phase_r;
    tag_nxt   = tag_r;
    size_nxt  = size_r;
    acc_nxt   = acc_r;
    tot_nxt   = tot_r;
    left_nxt  = left_r;
    emit      = 1'b0;
    st        = dtlv_pkg::ST_OK;
    if (start_req) begin
      tag_nxt  = data_byte;
      size_nxt = available_bytes;
      acc_nxt  = '0;
      tot_nxt  = '0;
      left_nxt = '0;
      if (available_bytes < 32'd2) begin
        emit      = 1'b1;
        st        = dtlv_pkg::ST_BUF_SHORT;
        phase_nxt = PH_SKIP;
      end else begin
        phase_nxt = PH_LEN;
      end
    end else begin
      case (phase_r)
        PH_LEN: begin
          emit      = 1'b1;
          phase_nxt = PH_SKIP;
          if ((data_byte & dtlv_pkg::LEN_LONG_MASK) == 8'd0) begin
            st = fin_past ? dtlv_pkg::ST_BODY_PAST : dtlv_pkg::ST_OK;
          end else if (n_oct == 7'd0 || n_oct > 7'(MAX_LEN_OCTETS)) begin
            st = dtlv_pkg::ST_BAD_FORM;
          end else if (size_r < (32'(n_oct) + 32'd2)) begin
            st = dtlv_pkg::ST_LEN_PAST;
          end else begin
            emit      = 1'b0;
            tot_nxt   = n_oct[2:0];
            left_nxt  = n_oct[2:0];
            acc_nxt   = '0;
            phase_nxt = PH_LONG;
          end
        end
        PH_LONG: begin
          if (left_r == tot_r && data_byte == 8'd0) begin
            emit      = 1'b1;
            st        = dtlv_pkg::ST_LEAD_ZERO;
            phase_nxt = PH_SKIP;
          end else begin
            acc_nxt  = acc_shift;
            left_nxt = left_r - 3'd1;
            if (left_r == 3'd1) begin
              emit      = 1'b1;
              phase_nxt = PH_SKIP;
              if (acc_shift < dtlv_pkg::SHORT_LIMIT) begin
                st = dtlv_pkg::ST_SHORT_REQ;
              end else begin
                st = fin_past ? dtlv_pkg::ST_BODY_PAST : dtlv_pkg::ST_OK;
              end
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      tag_r   <= '0;
      size_r  <= '0;
      acc_r   <= '0;
      tot_r   <= '0;
      left_r  <= '0;
    end else if (accept) begin
      phase_r <= phase_nxt;
      tag_r   <= tag_nxt;
      size_r  <= size_nxt;
      acc_r   <= acc_nxt;
      tot_r   <= tot_nxt;
      left_r  <= left_nxt;
    end
  end

  assign res_push = accept & emit;

  always_comb begin
    res_data.tag_byte       = tag_nxt;
    res_data.content_length = fin_len;
    res_data.head_len       = fin_hdr;
    res_data.status         = st;
  end

endmodule

// File: rtl/core/dtlv_queue.sv
// Short result queue between the front end and the output stage.
// Depends on dtlv_pkg.
module dtlv_queue (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       push,
  input  dtlv_pkg::result_t          push_data,
  input  logic                       pop,
  output logic                       full,
  output logic                       valid,
  output dtlv_pkg::result_t          head,
  output logic [dtlv_pkg::QCNT_W-1:0] count
);

  dtlv_pkg::result_t                mem_r [dtlv_pkg::QDEPTH];
  logic [dtlv_pkg::QPTR_W-1:0]      wr_r, wr_nxt;
  logic [dtlv_pkg::QPTR_W-1:0]      rd_r, rd_nxt;
  logic [dtlv_pkg::QCNT_W-1:0]      cnt_r, cnt_nxt;

  function automatic logic [dtlv_pkg::QCNT_W-1:0] QCNT_INC(input logic b);
    QCNT_INC = {{(dtlv_pkg::QCNT_W-1){1'b0}}, b};
  endfunction

  assign full  = cnt_r == dtlv_pkg::QCNT_W'(dtlv_pkg::QDEPTH);
  assign valid = cnt_r != '0;
  assign head  = mem_r[rd_r];
  assign count = cnt_r;

  always_comb begin
    wr_nxt  = push ? wr_r + 1'b1 : wr_r;
    rd_nxt  = pop ? rd_r + 1'b1 : rd_r;
    cnt_nxt = cnt_r + QCNT_INC(push) - QCNT_INC(pop);
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

// File: rtl/core/dtlv_back.sv
// Output stage: takes queued records, formats the result word and holds it until popped.
// Depends on dtlv_pkg.
module dtlv_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_valid,
  input  dtlv_pkg::result_t q_head,
  output logic              q_pop,
  input  logic              out_pop,
  output logic              out_empty,
  output logic [7:0]        out_tag_byte,
  output logic              out_constructed,
  output logic [31:0]       out_content_length,
  output logic [2:0]        out_head_len,
  output logic [2:0]        out_status
);

  logic        valid_r, valid_nxt;
  logic [7:0]  tag_r, tag_nxt;
  logic        cons_r, cons_nxt;
  logic [31:0] len_r, len_nxt;
  logic [2:0]  hdr_r, hdr_nxt;
  logic [2:0]  st_r, st_nxt;
  logic        ok;

  assign q_pop = q_valid & (~valid_r | out_pop);
  assign ok    = q_head.status == dtlv_pkg::ST_OK;

  always_comb begin
    valid_nxt = q_pop | (valid_r & ~out_pop);
    tag_nxt   = ok ? q_head.tag_byte : 8'd0;
    cons_nxt  = ok & ((q_head.tag_byte & dtlv_pkg::TAG_CONS_MASK) != 8'd0);
    len_nxt   = ok ? q_head.content_length : 32'd0;
    hdr_nxt   = ok ? q_head.head_len : 3'd0;
    st_nxt    = q_head.status;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      tag_r  <= tag_nxt;
      cons_r <= cons_nxt;
      len_r  <= len_nxt;
      hdr_r  <= hdr_nxt;
      st_r   <= st_nxt;
    end
  end

  assign out_empty          = ~valid_r;
  assign out_tag_byte       = tag_r;
  assign out_constructed    = cons_r;
  assign out_content_length = len_r;
  assign out_head_len       = hdr_r;
  assign out_status         = st_r;

endmodule
